// File: rtl/skc_pkg.sv
package skc_pkg;

  localparam int DECK_SIZE = 54;

  typedef logic [5:0] card_t;
  typedef logic [5:0] pos_t;
  typedef logic [4:0] letter_t;

  localparam card_t JOKER_A   = 6'd53;
  localparam card_t JOKER_B   = 6'd54;
  localparam card_t TOP_PLAIN = 6'd52;
  localparam pos_t  LAST_POS  = 6'(DECK_SIZE - 1);
  localparam pos_t  END_POS   = 6'(DECK_SIZE);

  typedef enum logic [1:0] {
    CMD_LOAD    = 2'd0,
    CMD_ENCRYPT = 2'd1,
    CMD_DECRYPT = 2'd2,
    CMD_UNUSED  = 2'd3
  } cmd_t;

  // Counting value of a card: jokers and anything above count 53.
  function automatic card_t count_of(input card_t c);
    count_of = (c > JOKER_A) ? JOKER_A : c;
  endfunction

  // Reduce a value below 104 modulo 26.
  function automatic logic [6:0] mod26(input logic [6:0] v);
    logic [6:0] r;
    r = v;
    for (int i = 0; i < 3; i++) begin
      if (r >= 7'd26) begin
        r = r - 7'd26;
      end
    end
    mod26 = r;
  endfunction

endpackage

// File: rtl/solitaire_keystream_cipher.sv
// Solitaire keystream cipher over a 54-card deck held in registers. Load commands
// write single cards of the initial deck; encrypt and decrypt commands optionally
// restart the working deck from the initial deck, then draw keystream values until
// one is not a joker or the draw limit is reached. The deck is worked on by a single
// rotate-by-one path with a swap at the top and a shift-in rebuild buffer, so every
// search, cut and lookup walks the deck one card per cycle. A letter goes through
// transfer, joker check scan, check and result hand-off, and each keystream draw in
// between goes through joker moves, joker scan, triple cut, count cut (skipped when
// the bottom card's count calls for no cut) and output lookup. A deck that lacks a
// joker gives its result, flagged as a deck error, after the check. The input
// is not taken while a letter is in work. A finished result moves into the output
// register and does not block the next command; only if that register still holds
// an earlier result does the finished letter wait, with the input stalled.
module solitaire_keystream_cipher (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_command,
  input  skc_pkg::pos_t      in_card_position,
  input  skc_pkg::card_t     in_card_value,
  input  skc_pkg::letter_t   in_letter_in,
  input  logic               in_start_of_message,
  output logic               out_valid,
  input  logic               out_stall,
  output skc_pkg::letter_t   out_letter_out,
  output logic               out_deck_error
);
  import skc_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE, S_SCAN_CHK, S_CHK, S_DRAW, S_SEEK, S_SWAP, S_STEP, S_ALIGN, S_JDONE,
    S_SCAN_TC, S_TC_SET, S_CUT, S_CUT_DONE, S_CC_SET, S_OUT_SET, S_OUT_SCAN,
    S_OUT_DEC, S_FIN
  } state_t;

  typedef enum logic [2:0] {
    D_HOLD, D_ROT, D_SWAP, D_LOAD_INIT, D_LOAD_BUF, D_LOAD_SAVED
  } deck_op_t;

  state_t   state_r, state_nxt;
  deck_op_t op;

  card_t init_r  [DECK_SIZE];
  card_t deck_r  [DECK_SIZE];
  card_t saved_r [DECK_SIZE];
  card_t buf_r   [DECK_SIZE];

  logic       init_we, save_en, buf_sh;
  pos_t       off_r, off_nxt, off_inc;
  logic       fa_r, fa_nxt, fb_r, fb_nxt;
  pos_t       pa_r, pa_nxt, pb_r, pb_nxt;
  logic       jb_r, jb_nxt;
  logic [1:0] moves_r, moves_nxt;
  logic [1:0] pass_r, pass_nxt;
  logic       cut_cc_r, cut_cc_nxt;
  pos_t       seg_a_r [3];
  pos_t       seg_e_r [3];
  pos_t       seg_a_nxt [3];
  pos_t       seg_e_nxt [3];
  card_t      m_r, m_nxt, c_r, c_nxt;
  logic [9:0] draws_r, draws_nxt;
  logic       dec_r, dec_nxt;
  letter_t    let_r, let_nxt;
  logic       err_r, err_nxt;
  letter_t    res_r, res_nxt;
  logic       out_valid_r, out_valid_nxt;
  letter_t    out_letter_r, out_letter_nxt;
  logic       out_err_r, out_err_nxt;

  pos_t       lo, hi, cnt_n, off_sw;
  card_t      target;
  letter_t    kval;
  logic [6:0] sum;

  assign in_stall       = (state_r != S_IDLE);
  assign out_valid      = out_valid_r;
  assign out_letter_out = out_letter_r;
  assign out_deck_error = out_err_r;

  assign off_inc = (off_r == LAST_POS) ? '0 : off_r + 6'd1;
  assign target  = jb_r ? JOKER_B : JOKER_A;
  assign lo      = (pa_r < pb_r) ? pa_r : pb_r;
  assign hi      = (pa_r < pb_r) ? pb_r : pa_r;
  assign cnt_n   = count_of(deck_r[DECK_SIZE-1]);
  assign off_sw  = (off_r == LAST_POS) ? '0 : off_r;
  assign kval    = (c_r == '0) ? 5'd26 :
                   (c_r > 6'd26) ? 5'(c_r - 6'd26) : 5'(c_r);
  assign sum     = dec_r ? (7'(let_r) + 7'd51 - 7'(kval))
                         : (7'(let_r) + 7'(kval) - 7'd1);

  always_comb begin
    state_nxt  = state_r;
    op         = D_HOLD;
    init_we    = 1'b0;
    save_en    = 1'b0;
    buf_sh     = 1'b0;
    off_nxt    = off_r;
    fa_nxt     = fa_r;
    fb_nxt     = fb_r;
    pa_nxt     = pa_r;
    pb_nxt     = pb_r;
    jb_nxt     = jb_r;
    moves_nxt  = moves_r;
    pass_nxt   = pass_r;
    cut_cc_nxt = cut_cc_r;
    seg_a_nxt  = seg_a_r;
    seg_e_nxt  = seg_e_r;
    m_nxt      = m_r;
    c_nxt      = c_r;
    draws_nxt  = draws_r;
    dec_nxt    = dec_r;
    let_nxt    = let_r;
    err_nxt    = err_r;
    res_nxt    = res_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_letter_nxt = out_letter_r;
    out_err_nxt    = out_err_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          case (in_command)
            CMD_LOAD: begin
              init_we = (in_card_position < END_POS);
            end
            CMD_ENCRYPT, CMD_DECRYPT: begin
              dec_nxt = (in_command == CMD_DECRYPT);
              let_nxt = in_letter_in;
              if (in_start_of_message) begin
                op = D_LOAD_INIT;
              end
              fa_nxt    = 1'b0;
              fb_nxt    = 1'b0;
              off_nxt   = '0;
              state_nxt = S_SCAN_CHK;
            end
            default: ;
          endcase
        end
      end
      S_SCAN_CHK, S_SCAN_TC: begin
        // One full rotation; the deck ends where it started.
        op = D_ROT;
        if (deck_r[0] == JOKER_A && !fa_r) begin
          fa_nxt = 1'b1;
          pa_nxt = off_r;
        end
        if (deck_r[0] == JOKER_B && !fb_r) begin
          fb_nxt = 1'b1;
          pb_nxt = off_r;
        end
        off_nxt = off_inc;
        if (off_r == LAST_POS) begin
          state_nxt = (state_r == S_SCAN_CHK) ? S_CHK : S_TC_SET;
        end
      end
      S_CHK: begin
        if (!(fa_r && fb_r)) begin
          err_nxt   = 1'b1;
          res_nxt   = '0;
          state_nxt = S_FIN;
        end else begin
          save_en   = 1'b1;
          draws_nxt = '0;
          state_nxt = S_DRAW;
        end
      end
      S_DRAW: begin
        jb_nxt    = 1'b0;
        moves_nxt = 2'd1;
        state_nxt = S_SEEK;
      end
      S_SEEK: begin
        if (deck_r[0] == target) begin
          state_nxt = S_SWAP;
        end else begin
          op      = D_ROT;
          off_nxt = off_inc;
        end
      end
      S_SWAP: begin
        // At the bottom the swap itself leaves the deck in its home frame.
        op        = D_SWAP;
        moves_nxt = moves_r - 2'd1;
        off_nxt   = off_sw;
        if (moves_r == 2'd2) begin
          state_nxt = S_STEP;
        end else if (off_sw == '0) begin
          state_nxt = S_JDONE;
        end else begin
          state_nxt = S_ALIGN;
        end
      end
      S_STEP: begin
        op        = D_ROT;
        off_nxt   = off_inc;
        state_nxt = S_SWAP;
      end
      S_ALIGN: begin
        op      = D_ROT;
        off_nxt = off_inc;
        if (off_r == LAST_POS) begin
          state_nxt = S_JDONE;
        end
      end
      S_JDONE: begin
        if (jb_r) begin
          fa_nxt    = 1'b0;
          fb_nxt    = 1'b0;
          state_nxt = S_SCAN_TC;
        end else begin
          jb_nxt    = 1'b1;
          moves_nxt = 2'd2;
          state_nxt = S_SEEK;
        end
      end
      S_TC_SET: begin
        seg_a_nxt[0] = hi + 6'd1;
        seg_e_nxt[0] = END_POS;
        seg_a_nxt[1] = lo;
        seg_e_nxt[1] = hi + 6'd1;
        seg_a_nxt[2] = '0;
        seg_e_nxt[2] = lo;
        pass_nxt     = '0;
        cut_cc_nxt   = 1'b0;
        state_nxt    = S_CUT;
      end
      S_CUT: begin
        // Three rotations; each transfers one position range into the buffer.
        op      = D_ROT;
        buf_sh  = (off_r >= seg_a_r[pass_r]) && (off_r < seg_e_r[pass_r]);
        off_nxt = off_inc;
        if (off_r == LAST_POS) begin
          pass_nxt = pass_r + 2'd1;
          if (pass_r == 2'd2) begin
            state_nxt = S_CUT_DONE;
          end
        end
      end
      S_CUT_DONE: begin
        op        = D_LOAD_BUF;
        state_nxt = cut_cc_r ? S_OUT_SET : S_CC_SET;
      end
      S_CC_SET: begin
        if (cnt_n == '0 || cnt_n >= LAST_POS) begin
          state_nxt = S_OUT_SET;
        end else begin
          seg_a_nxt[0] = cnt_n;
          seg_e_nxt[0] = LAST_POS;
          seg_a_nxt[1] = '0;
          seg_e_nxt[1] = cnt_n;
          seg_a_nxt[2] = LAST_POS;
          seg_e_nxt[2] = END_POS;
          pass_nxt     = '0;
          cut_cc_nxt   = 1'b1;
          state_nxt    = S_CUT;
        end
      end
      S_OUT_SET: begin
        m_nxt     = count_of(deck_r[0]);
        state_nxt = S_OUT_SCAN;
      end
      S_OUT_SCAN: begin
        op = D_ROT;
        if (off_r == m_r) begin
          c_nxt = deck_r[0];
        end
        off_nxt = off_inc;
        if (off_r == LAST_POS) begin
          state_nxt = S_OUT_DEC;
        end
      end
      S_OUT_DEC: begin
        if (c_r > TOP_PLAIN) begin
          if (draws_r == '1) begin
            op        = D_LOAD_SAVED;
            err_nxt   = 1'b1;
            res_nxt   = '0;
            state_nxt = S_FIN;
          end else begin
            draws_nxt = draws_r + 10'd1;
            state_nxt = S_DRAW;
          end
        end else begin
          err_nxt   = 1'b0;
          res_nxt   = 5'(mod26(sum)) + 5'd1;
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt  = 1'b1;
          out_letter_nxt = res_r;
          out_err_nxt    = err_r;
          state_nxt      = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      off_r       <= '0;
      fa_r        <= 1'b0;
      fb_r        <= 1'b0;
      jb_r        <= 1'b0;
      moves_r     <= '0;
      pass_r      <= '0;
      cut_cc_r    <= 1'b0;
      draws_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      off_r       <= off_nxt;
      fa_r        <= fa_nxt;
      fb_r        <= fb_nxt;
      jb_r        <= jb_nxt;
      moves_r     <= moves_nxt;
      pass_r      <= pass_nxt;
      cut_cc_r    <= cut_cc_nxt;
      draws_r     <= draws_nxt;
      out_valid_r <= out_valid_nxt;
    end
    pa_r         <= pa_nxt;
    pb_r         <= pb_nxt;
    seg_a_r      <= seg_a_nxt;
    seg_e_r      <= seg_e_nxt;
    m_r          <= m_nxt;
    c_r          <= c_nxt;
    dec_r        <= dec_nxt;
    let_r        <= let_nxt;
    err_r        <= err_nxt;
    res_r        <= res_nxt;
    out_letter_r <= out_letter_nxt;
    out_err_r    <= out_err_nxt;
  end

  always_ff @(posedge clk) begin
    if (init_we) begin
      init_r[in_card_position] <= in_card_value;
    end
    if (save_en) begin
      saved_r <= deck_r;
    end
    if (buf_sh) begin
      for (int i = 0; i < DECK_SIZE - 1; i++) begin
        buf_r[i] <= buf_r[i+1];
      end
      buf_r[DECK_SIZE-1] <= deck_r[0];
    end
    case (op)
      D_ROT: begin
        for (int i = 0; i < DECK_SIZE - 1; i++) begin
          deck_r[i] <= deck_r[i+1];
        end
        deck_r[DECK_SIZE-1] <= deck_r[0];
      end
      D_SWAP: begin
        deck_r[0] <= deck_r[1];
        deck_r[1] <= deck_r[0];
      end
      D_LOAD_INIT:  deck_r <= init_r;
      D_LOAD_BUF:   deck_r <= buf_r;
      D_LOAD_SAVED: deck_r <= saved_r;
      default: ;
    endcase
  end

  a_swap_on_joker: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_SWAP |-> deck_r[0] == target)
    else $error("swap without the joker on top");

  a_off_range: assert property (@(posedge clk) disable iff (!rst_n)
    off_r <= LAST_POS)
    else $error("deck offset out of range");

  a_result_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_err_r ? (out_letter_r == '0)
                               : (out_letter_r >= 5'd1 && out_letter_r <= 5'd26)))
    else $error("malformed result");

endmodule
